// File: hw/rtl/pkc_pkg.sv
// ----------------------------------------------------------------------------
// pkc_pkg
// Shared types, constants, keyword tables and helpers for the payload keyword
// classifier.
// ----------------------------------------------------------------------------
package pkc_pkg;

   localparam int KEPT_LIMIT   = 500;
   localparam int WINDOW_LEN   = 11;
   localparam int NUM_KW       = 28;
   localparam int NUM_GROUPS   = 8;
   localparam int KW_BYTES     = 11;
   localparam int KW_TEXT_W    = KW_BYTES * 8;
   localparam int KW_LEN_W     = 4;
   localparam int TECH_W       = 4;
   localparam int SCORE_W      = 14;
   localparam int CNT_W        = $clog2(KEPT_LIMIT + 1);
   localparam int WIN_W        = WINDOW_LEN * 8;
   localparam int HIST_W       = (WINDOW_LEN - 1) * 8;
   localparam int MARKER_BYTES = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0]   KEPT_MAX    = CNT_W'(KEPT_LIMIT);
   localparam logic [SCORE_W-1:0] SCORE_EMPTY = SCORE_W'(3000);
   localparam logic [SCORE_W-1:0] SCORE_BASE  = SCORE_W'(6500);
   localparam logic [SCORE_W-1:0] SCORE_MAX   = SCORE_W'(10000);
   localparam logic [SCORE_W-1:0] SCORE_MARK  = SCORE_W'(MARKER_BYTES);

   localparam logic [TECH_W-1:0] TECH_SQLI     = 4'd0;
   localparam logic [TECH_W-1:0] TECH_COMMAND  = 4'd1;
   localparam logic [TECH_W-1:0] TECH_TOOL     = 4'd2;
   localparam logic [TECH_W-1:0] TECH_SCAN     = 4'd3;
   localparam logic [TECH_W-1:0] TECH_BRUTE    = 4'd4;
   localparam logic [TECH_W-1:0] TECH_TRAVERSE = 4'd5;
   localparam logic [TECH_W-1:0] TECH_SHELL    = 4'd6;
   localparam logic [TECH_W-1:0] TECH_ACTIVE   = 4'd7;
   localparam logic [TECH_W-1:0] TECH_DEFAULT  = 4'd8;

   localparam logic [7:0] CHAR_DOT = 8'h2e;

   typedef logic [KW_TEXT_W-1:0] kw_text_type;
   typedef logic [KW_LEN_W-1:0]  kw_len_type;
   typedef logic [TECH_W-1:0]    kw_group_type;

   // keyword text right aligned: last character in the low byte
   localparam kw_text_type KW_TEXT [NUM_KW] = '{
      KW_TEXT_W'("select"), KW_TEXT_W'("union"), KW_TEXT_W'("drop"),
      KW_TEXT_W'("insert"),
      KW_TEXT_W'("/etc/passwd"), KW_TEXT_W'("/bin/"), KW_TEXT_W'("cmd="),
      KW_TEXT_W'("exec"),
      KW_TEXT_W'("wget"), KW_TEXT_W'("curl"), KW_TEXT_W'("base64"),
      KW_TEXT_W'("eval"),
      KW_TEXT_W'(32'h6e6d6170), KW_TEXT_W'("scan"), KW_TEXT_W'("probe"),
      KW_TEXT_W'("admin"), KW_TEXT_W'("root"), KW_TEXT_W'("password"),
      KW_TEXT_W'("ssh"),
      KW_TEXT_W'("../"), KW_TEXT_W'("..\\"), KW_TEXT_W'("etc/passwd"),
      KW_TEXT_W'("<?php"), KW_TEXT_W'("<script"), KW_TEXT_W'("powershell"),
      KW_TEXT_W'("cmd.exe"),
      KW_TEXT_W'("user-agent"), KW_TEXT_W'(48'h73716c6d6170)
   };

   localparam kw_len_type KW_LEN [NUM_KW] = '{
      4'd6, 4'd5, 4'd4, 4'd6,
      4'd11, 4'd5, 4'd4, 4'd4,
      4'd4, 4'd4, 4'd6, 4'd4,
      4'd4, 4'd4, 4'd5,
      4'd5, 4'd4, 4'd8, 4'd3,
      4'd3, 4'd3, 4'd10,
      4'd5, 4'd7, 4'd10, 4'd7,
      4'd10, 4'd6
   };

   localparam kw_group_type KW_GROUP [NUM_KW] = '{
      TECH_SQLI, TECH_SQLI, TECH_SQLI, TECH_SQLI,
      TECH_COMMAND, TECH_COMMAND, TECH_COMMAND, TECH_COMMAND,
      TECH_TOOL, TECH_TOOL, TECH_TOOL, TECH_TOOL,
      TECH_SCAN, TECH_SCAN, TECH_SCAN,
      TECH_BRUTE, TECH_BRUTE, TECH_BRUTE, TECH_BRUTE,
      TECH_TRAVERSE, TECH_TRAVERSE, TECH_TRAVERSE,
      TECH_SHELL, TECH_SHELL, TECH_SHELL, TECH_SHELL,
      TECH_ACTIVE, TECH_ACTIVE
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [TECH_W-1:0]  technique;
      logic [SCORE_W-1:0] score_hundredths;
   } rsp_type;

   typedef struct packed {
      logic [NUM_KW-1:0] hits;
      logic [CNT_W-1:0]  kept;
      logic              overflowed;
   } summary_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [7:0] clean_byte(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (!((b >= 8'd32 && b < 8'd127) || b == 8'd9 || b == 8'd10 || b == 8'd13)) begin
         c = CHAR_DOT;
      end
      if (c >= 8'h41 && c <= 8'h5a) begin
         c = c + 8'd32;
      end
      return c;
   endfunction

   function automatic kw_text_type kw_mask(input kw_len_type len);
      return ~({KW_TEXT_W{1'b1}} << ({3'b000, len} << 3));
   endfunction

endpackage

// File: hw/rtl/pkc_front.sv
// ----------------------------------------------------------------------------
// pkc_front
// Cleans each payload byte, slides the match window, keeps sticky keyword
// hits and the kept count, and emits a session summary on the last beat.
// ----------------------------------------------------------------------------
module pkc_front import pkc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   output logic        sum_push,
   output summary_type sum_data
);

   logic [HIST_W-1:0] window_ff, window_in;
   logic [NUM_KW-1:0] hits_ff, hits_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;

   logic [7:0]        cleaned;
   logic [WIN_W-1:0]  win;
   logic [NUM_KW-1:0] match;
   logic              take;
   logic              drop;
   logic [HIST_W-1:0] window_upd;
   logic [NUM_KW-1:0] hits_upd;
   logic [CNT_W-1:0]  count_upd;
   logic              ovf_upd;

   always_comb begin
      cleaned = clean_byte(req_data.data_byte);
      win     = {window_ff, cleaned};
      for (int k = 0; k < NUM_KW; k++) begin
         match[k] = ((win[KW_TEXT_W-1:0] ^ KW_TEXT[k]) & kw_mask(KW_LEN[k])) == '0;
      end
      take = accept && req_data.byte_valid && (count_ff < KEPT_MAX);
      drop = accept && req_data.byte_valid && (count_ff >= KEPT_MAX);

      window_upd = take ? win[HIST_W-1:0] : window_ff;
      hits_upd   = take ? (hits_ff | match) : hits_ff;
      count_upd  = take ? count_ff + CNT_W'(1) : count_ff;
      ovf_upd    = ovf_ff | drop;

      sum_push = accept && req_data.last;
      sum_data = '{hits: hits_upd, kept: count_upd, overflowed: ovf_upd};

      if (sum_push) begin
         window_in = '0;
         hits_in   = '0;
         count_in  = '0;
         ovf_in    = 1'b0;
      end else begin
         window_in = window_upd;
         hits_in   = hits_upd;
         count_in  = count_upd;
         ovf_in    = ovf_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         hits_ff   <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         window_ff <= window_in;
         hits_ff   <= hits_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= KEPT_MAX)
      else $error("kept count beyond limit");

   a_ovf_full : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == KEPT_MAX)
      else $error("overflow flagged before limit reached");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      sum_push |=> (count_ff == '0 && hits_ff == '0 && !ovf_ff))
      else $error("session state not cleared after last beat");

endmodule

// File: hw/rtl/pkc_queue.sv
// ----------------------------------------------------------------------------
// pkc_queue
// Short summary queue between the front and back parts.
// ----------------------------------------------------------------------------
module pkc_queue import pkc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_ctrl_type ctrl,
   input  summary_type    wr_data,
   output queue_stat_type stat,
   output summary_type    rd_data
);

   summary_type       store [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      stat.full  = fill_ff == QCNT_W'(QUEUE_DEPTH);
      stat.empty = fill_ff == '0;
      do_push    = ctrl.push && !stat.full;
      do_pop     = ctrl.pop && !stat.empty;
      wr_ptr_in  = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in    = fill_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      rd_data    = store[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && stat.full))
      else $error("summary pushed into full queue");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers apart while empty");

endmodule

// File: hw/rtl/pkc_back.sv
// ----------------------------------------------------------------------------
// pkc_back
// Turns a session summary into technique and score and holds it in the
// result register until taken.
// ----------------------------------------------------------------------------
module pkc_back import pkc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  summary_type q_data,
   output logic        q_pop,
   input  logic        pop,
   output logic        empty,
   output rsp_type     rsp_data
);

   logic                  valid_ff, valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [NUM_GROUPS-1:0] grp_any;
   logic [TECH_W-1:0]     tech;
   logic [SCORE_W-1:0]    eff;
   logic [SCORE_W-1:0]    raw;
   logic [SCORE_W-1:0]    score;
   logic                  is_empty;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any[g] = 1'b0;
         for (int k = 0; k < NUM_KW; k++) begin
            if (KW_GROUP[k] == TECH_W'(g) && q_data.hits[k]) begin
               grp_any[g] = 1'b1;
            end
         end
      end
      tech = TECH_DEFAULT;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            tech = TECH_W'(g);
         end
      end

      eff      = SCORE_W'(q_data.kept) + (q_data.overflowed ? SCORE_MARK : '0);
      raw      = SCORE_BASE + eff;
      score    = (raw > SCORE_MAX) ? SCORE_MAX : raw;
      is_empty = (q_data.kept == '0) && !q_data.overflowed;

      q_pop = !q_empty && (!valid_ff || pop);

      if (is_empty) begin
         rsp_in = '{technique: TECH_SCAN, score_hundredths: SCORE_EMPTY};
      end else begin
         rsp_in = '{technique: tech, score_hundredths: score};
      end

      if (q_pop) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      empty    = !valid_ff;
      rsp_data = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   a_empty_scan : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.score_hundredths == SCORE_EMPTY)
         |-> rsp_data.technique == TECH_SCAN)
      else $error("empty payload score without scan technique");

   a_score_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.score_hundredths == SCORE_EMPTY
                  || (rsp_data.score_hundredths >= SCORE_BASE
                      && rsp_data.score_hundredths <= SCORE_MAX)))
      else $error("score out of range");

   a_load_shown : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !empty)
      else $error("loaded result not shown");

endmodule

// File: hw/rtl/payload_keyword_classifier_top.sv
// ----------------------------------------------------------------------------
// payload_keyword_classifier_top
// Payload keyword classifier: byte cleaning, keyword window match and
// session technique and score result.
// ----------------------------------------------------------------------------
// result path: a beat with last writes its summary into the summary queue, and the
// summary moves into the result register once that register is empty or being taken
// throughput: one beat per cycle while full is low, with a combinational window match
// full rises only when the 4-entry summary queue is full
// reset: synchronous, clears window, hits, counts, queue and result valid
// ----------------------------------------------------------------------------
module payload_keyword_classifier_top import pkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic           accept;
   logic           sum_push;
   summary_type    sum_data;
   summary_type    q_data;
   queue_ctrl_type q_ctrl;
   queue_stat_type q_stat;
   logic           q_pop;

   assign full   = q_stat.full;
   assign accept = push && !q_stat.full;

   always_comb begin
      q_ctrl.push = sum_push;
      q_ctrl.pop  = q_pop;
   end

   pkc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .sum_push (sum_push),
      .sum_data (sum_data)
   );

   pkc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (q_ctrl),
      .wr_data (sum_data),
      .stat    (q_stat),
      .rd_data (q_data)
   );

   pkc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_stat.empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule
